FILE: hdl/gne_pkg.sv
package gne_pkg;

    // field widths
    localparam int SIDE_W       = 7;
    localparam int CELLS_W      = 2 * SIDE_W;
    localparam int ID_W         = 13;
    localparam int CMD_W        = 2;
    localparam int CTR_W        = 7;

    // stream and config port widths
    localparam int IN_TDATA_W   = 16;
    localparam int IN_TUSER_W   = CMD_W;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 2;
    localparam int OUT_PAD_W    = OUT_TDATA_W - ID_W - 2 * CTR_W;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = SIDE_W;

    // divider digits per cycle
    localparam int DIV_BITS     = 4;

    // neighbors per cell
    localparam int NB_N         = 4;

    localparam int DEF_MAX_SIDE = 64;

    localparam logic [SIDE_W-1:0] RST_GRID_SIDE   = 7'd64;
    localparam logic              RST_HONOR_LOCKS = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_LOCK   = 2'd1,
        CMD_UNLOCK = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIDE   = 1'b0,
        CFG_HONOR_LOCKS = 1'b1
    } t_cfg_idx;

    // classified word handed from front to back
    typedef struct packed {
        t_cmd            cmd;
        logic [ID_W-1:0] id;
        logic            bad;
    } t_job;

    typedef struct packed {
        logic             nvalid;
        logic [ID_W-1:0]  nid;
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
        logic             bad;
        logic             last;
    } t_result;

endpackage

FILE: hdl/gne_front.sv
module gne_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  gne_pkg::t_cmd              i_cmd,
    input  logic [gne_pkg::ID_W-1:0]   i_id,
    input  logic [gne_pkg::CELLS_W-1:0] i_cells,
    input  logic                       i_hold,
    output logic                       o_job_valid,
    output gne_pkg::t_job              o_job,
    input  logic                       i_pop
);
    import gne_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = 1;

    t_job            r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;

    t_job            s_in;
    logic            s_push;
    logic            s_pop;

    // range check against the current cell count
    assign s_in.cmd = i_cmd;
    assign s_in.id  = i_id;
    assign s_in.bad = (i_id == '0) || (CELLS_W'(i_id) > i_cells);

    assign o_ready     = (r_count != (PW+1)'(DEPTH)) && !i_hold;
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_slot[r_rd_ptr];

    assign s_push = i_valid && o_ready;
    assign s_pop  = i_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_slot[r_wr_ptr] <= s_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!s_push && s_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/gne_div.sv
module gne_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gne_pkg::ID_W-1:0]    i_dividend,
    input  logic [gne_pkg::SIDE_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [gne_pkg::SIDE_W-1:0]  o_quot,
    output logic [gne_pkg::SIDE_W-1:0]  o_rem
);
    import gne_pkg::*;

    localparam int STEPS = (ID_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W = STEPS * DIV_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int REM_W = SIDE_W + 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [PAD_W-1:0] r_dvd;
    logic [PAD_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;

    logic [PAD_W-1:0] s_dvd;
    logic [PAD_W-1:0] s_quo;
    logic [REM_W-1:0] s_rem;
    logic [REM_W-1:0] s_den;

    assign s_den = {1'b0, i_divisor};

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        s_rem = r_rem;
        s_dvd = r_dvd;
        s_quo = r_quo;
        for (int i = 0; i < DIV_BITS; i++) begin
            s_rem = {s_rem[REM_W-2:0], s_dvd[PAD_W-1]};
            s_dvd = {s_dvd[PAD_W-2:0], 1'b0};
            if (s_rem >= s_den) begin
                s_rem = s_rem - s_den;
                s_quo = {s_quo[PAD_W-2:0], 1'b1};
            end else begin
                s_quo = {s_quo[PAD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= PAD_W'(i_dividend);
                r_quo  <= '0;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= s_dvd;
                r_quo <= s_quo;
                r_rem <= s_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo[SIDE_W-1:0];
    assign o_rem  = r_rem[SIDE_W-1:0];

endmodule

FILE: hdl/gne_back.sv
module gne_back #(
    parameter int MAX_SIDE = gne_pkg::DEF_MAX_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  gne_pkg::t_job               i_job,
    output logic                        o_pop,
    output logic                        o_clearing,
    input  logic [gne_pkg::SIDE_W-1:0]  i_side,
    input  logic                        i_honor,
    output logic                        o_div_start,
    output logic [gne_pkg::ID_W-1:0]    o_div_dividend,
    input  logic                        i_div_done,
    input  logic [gne_pkg::SIDE_W-1:0]  i_div_quot,
    input  logic [gne_pkg::SIDE_W-1:0]  i_div_rem,
    output logic                        o_valid,
    input  logic                        i_ready,
    output gne_pkg::t_result            o_result
);
    import gne_pkg::*;

    localparam int MAP_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_LOOK,
        ST_EMIT
    } t_state;

    t_state              r_state,    n_state;
    logic [MAP_AW-1:0]   r_clr_addr, n_clr_addr;
    logic [ID_W-1:0]     r_id,       n_id;
    logic [SIDE_W-1:0]   r_row,      n_row;
    logic [SIDE_W-1:0]   r_col,      n_col;
    logic [NB_N-1:0]     r_exist,    n_exist;
    logic [NB_N-1:0]     r_open,     n_open;
    logic [2:0]          r_k,        n_k;
    logic                r_out_valid, n_out_valid;
    t_result             r_out,      n_out;

    // blocked-cell bitmap, one read and one write port
    logic                r_map [MAP_DEPTH];
    logic                r_rd_bit;

    logic                s_we;
    logic [MAP_AW-1:0]   s_wa;
    logic                s_wd;
    logic [MAP_AW-1:0]   s_ra;
    logic [ID_W-1:0]     s_ra_id;
    logic [ID_W-1:0]     s_wa_id;
    logic [ID_W-1:0]     s_nb [NB_N];
    logic                s_out_free;
    logic [1:0]          s_sel;
    logic [NB_N-1:0]     s_rest;
    logic [1:0]          s_prev;
    logic [SIDE_W:0]     s_side_x;
    logic [CTR_W-1:0]    s_cx;
    logic [CTR_W-1:0]    s_cy;

    // left, right, up, down
    assign s_nb[0] = r_id - ID_W'(1);
    assign s_nb[1] = r_id + ID_W'(1);
    assign s_nb[2] = r_id - ID_W'(i_side);
    assign s_nb[3] = r_id + ID_W'(i_side);

    assign s_ra_id = s_nb[r_k[1:0]] - ID_W'(1);
    assign s_ra    = MAP_AW'(s_ra_id);
    assign s_wa_id = i_job.id - ID_W'(1);
    assign s_prev  = 2'(r_k - 3'd1);
    assign s_side_x = {1'b0, i_side};

    assign s_out_free = !r_out_valid || i_ready;

    // centre in half-cell units: 2*n + 1
    assign s_cx = CTR_W'({r_col, 1'b1});
    assign s_cy = CTR_W'({r_row, 1'b1});

    // lowest open neighbor goes first
    always_comb begin
        s_sel  = 2'd0;
        s_rest = r_open;
        for (int j = NB_N - 1; j >= 0; j--) begin
            if (r_open[j]) begin
                s_sel = 2'(j);
            end
        end
        s_rest[s_sel] = 1'b0;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_id        = r_id;
        n_row       = r_row;
        n_col       = r_col;
        n_exist     = r_exist;
        n_open      = r_open;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        o_div_start = 1'b0;
        s_we        = 1'b0;
        s_wa        = r_clr_addr;
        s_wd        = 1'b0;

        if (i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                s_we       = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == MAP_AW'(MAP_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.cmd == CMD_CLEAR) begin
                        o_pop      = 1'b1;
                        n_clr_addr = '0;
                        n_state    = ST_CLEAR;
                    end else if (i_job.bad) begin
                        if (s_out_free) begin
                            o_pop       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.bad   = 1'b1;
                            n_out.last  = 1'b1;
                        end
                    end else if (i_job.cmd == CMD_LOCK || i_job.cmd == CMD_UNLOCK) begin
                        o_pop = 1'b1;
                        s_we  = 1'b1;
                        s_wa  = MAP_AW'(s_wa_id);
                        s_wd  = (i_job.cmd == CMD_LOCK);
                    end else begin
                        o_pop       = 1'b1;
                        o_div_start = 1'b1;
                        n_id        = i_job.id;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    n_row      = i_div_quot;
                    n_col      = i_div_rem;
                    n_exist[0] = (i_div_rem != '0);
                    n_exist[1] = ({1'b0, i_div_rem} + 1'b1) < s_side_x;
                    n_exist[2] = (i_div_quot != '0);
                    n_exist[3] = ({1'b0, i_div_quot} + 1'b1) < s_side_x;
                    n_open     = '0;
                    n_k        = '0;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // read issued for r_k, data for r_k - 1 arrives now
                if (r_k != 3'd0) begin
                    n_open[s_prev] = r_exist[s_prev] && (!i_honor || !r_rd_bit);
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'(NB_N)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (s_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.cx    = s_cx;
                    n_out.cy    = s_cy;
                    n_out.bad   = 1'b0;
                    if (r_open == '0) begin
                        n_out.nvalid = 1'b0;
                        n_out.nid    = '0;
                        n_out.last   = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_out.nvalid = 1'b1;
                        n_out.nid    = s_nb[s_sel];
                        n_out.last   = (s_rest == '0);
                        n_open       = s_rest;
                        if (s_rest == '0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_id    <= n_id;
        r_row   <= n_row;
        r_col   <= n_col;
        r_exist <= n_exist;
        r_open  <= n_open;
        r_k     <= n_k;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_map[s_wa] <= s_wd;
        end
        r_rd_bit <= r_map[s_ra];
    end

    assign o_clearing     = (r_state == ST_CLEAR);
    assign o_div_dividend = s_wa_id;
    assign o_valid        = r_out_valid;
    assign o_result       = r_out;

endmodule

FILE: hdl/grid_neighbor_enumerator_unit.sv
// Square-grid neighbor enumerator. Cells are numbered from 1 in row-major order on a
// grid of grid_side x grid_side (config register 0, clamped to 1..MAX_SIDE); a
// blocked-cell bitmap of MAX_SIDE^2 bits is set by lock, cleared by unlock, and wiped
// by clear. A query word returns its in-grid 4-neighbors in the order left, right, up,
// down, one output word each with tlast on the final one; with honor_locks (register
// 1) set, blocked neighbors are skipped, and a query with none listed returns a single
// word with neighbor_valid low. Every word of an in-grid query carries the cell center
// as 2*col+1 and 2*row+1. An id of zero or beyond the grid returns one word with
// bad_cell set and leaves the map alone; clear ignores the id. An accepted word
// reaches the sequencer through the queue. Lock and unlock of an in-grid id make no
// output word. A query goes through the row/column divider (4 quotient bits at a
// time), then neighbor lookups through the single bitmap read port, then output.
// Clear sweeps the bitmap one bit per cycle; the bitmap wipe after reset is the same
// sweep. s_axis_tready is low throughout a sweep. A two-word queue sits between the
// input classifier and the sequencer, and the output word is registered, so input
// and output stall independently. Config writes are always accepted and must only
// happen while idle.
module grid_neighbor_enumerator_unit #(
    parameter int MAX_SIDE = gne_pkg::DEF_MAX_SIDE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gne_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [12:0] cell_id
    input  logic [gne_pkg::IN_TUSER_W-1:0]    s_axis_tuser,   // [1:0] command
    // output words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gne_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [12:0] neighbor_id,
                                                              // [19:13] center_x_half,
                                                              // [26:20] center_y_half
    output logic [gne_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,   // [0] neighbor_valid,
                                                              // [1] bad_cell
    output logic                              m_axis_tlast,
    // config writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gne_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gne_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gne_pkg::*;

    // reset side after clamping to MAX_SIDE
    localparam int RST_SIDE_INT = (int'(RST_GRID_SIDE) > MAX_SIDE) ? MAX_SIDE
                                                                  : int'(RST_GRID_SIDE);
    localparam logic [SIDE_W-1:0]  RST_SIDE  = SIDE_W'(RST_SIDE_INT);
    localparam logic [CELLS_W-1:0] RST_CELLS = CELLS_W'(RST_SIDE_INT * RST_SIDE_INT);

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] w);
        logic [SIDE_W-1:0] s;
        s = w;
        if (w == '0) begin
            s = SIDE_W'(1);
        end else if (int'(w) > MAX_SIDE) begin
            s = SIDE_W'(MAX_SIDE);
        end
        return s;
    endfunction

    logic [SIDE_W-1:0]  r_side,  n_side;
    logic [CELLS_W-1:0] r_cells, n_cells;
    logic               r_honor, n_honor;

    logic [SIDE_W-1:0]  s_side_wr;
    logic [CELLS_W-1:0] s_cells_wr;

    t_job               s_job;
    logic               s_job_valid;
    logic               s_pop;
    logic               s_clearing;
    logic               s_div_start;
    logic [ID_W-1:0]    s_div_dividend;
    logic               s_div_done;
    logic [SIDE_W-1:0]  s_div_quot;
    logic [SIDE_W-1:0]  s_div_rem;
    t_result            s_result;

    // ---------------------------------------------------------------
    // config registers; cell count is precomputed at write time so the
    // range check on the next input word sees it at once
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign s_side_wr   = clamp_side(i_cfg_data);
    assign s_cells_wr  = CELLS_W'(s_side_wr) * CELLS_W'(s_side_wr);

    always_comb begin
        n_side  = r_side;
        n_cells = r_cells;
        n_honor = r_honor;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_SIDE: begin
                    n_side  = s_side_wr;
                    n_cells = s_cells_wr;
                end
                CFG_HONOR_LOCKS: begin
                    n_honor = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= RST_SIDE;
            r_cells <= RST_CELLS;
            r_honor <= RST_HONOR_LOCKS;
        end else begin
            r_side  <= n_side;
            r_cells <= n_cells;
            r_honor <= n_honor;
        end
    end

    // ---------------------------------------------------------------
    // front: accept, range-check, queue
    // ---------------------------------------------------------------
    gne_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .i_id        (s_axis_tdata[ID_W-1:0]),
        .i_cells     (r_cells),
        .i_hold      (s_clearing),
        .o_job_valid (s_job_valid),
        .o_job       (s_job),
        .i_pop       (s_pop)
    );

    // ---------------------------------------------------------------
    // id - 1 split into row and column
    // ---------------------------------------------------------------
    gne_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (s_div_dividend),
        .i_divisor  (r_side),
        .o_done     (s_div_done),
        .o_quot     (s_div_quot),
        .o_rem      (s_div_rem)
    );

    // ---------------------------------------------------------------
    // back: bitmap, neighbor lookup, output word register
    // ---------------------------------------------------------------
    gne_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (s_job_valid),
        .i_job          (s_job),
        .o_pop          (s_pop),
        .o_clearing     (s_clearing),
        .i_side         (r_side),
        .i_honor        (r_honor),
        .o_div_start    (s_div_start),
        .o_div_dividend (s_div_dividend),
        .i_div_done     (s_div_done),
        .i_div_quot     (s_div_quot),
        .i_div_rem      (s_div_rem),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_result       (s_result)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, s_result.cy, s_result.cx, s_result.nid};
    assign m_axis_tuser = {s_result.bad, s_result.nvalid};
    assign m_axis_tlast = s_result.last;

`ifndef SYNTHESIS
    // nothing enters while the bitmap is being wiped
    a_hold_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_clearing |-> !s_axis_tready)
        else $error("input accepted during bitmap clear");

    // a bad-id word is alone and lists no neighbor
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && m_axis_tlast))
        else $error("bad-id word with neighbor or without last");

    // a listed neighbor always has a real id
    a_nb_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[ID_W-1:0] != '0))
        else $error("listed neighbor with zero id");

    // the back pops nothing right after it starts the divider
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_start |=> !s_pop)
        else $error("back popped a word while the divider was starting");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for grid_neighbor_enumerator_unit.
//
// A scoreboard object mirrors the block: it holds its own copy of the blocked
// map, the side and the honor_locks setting. Each accepted input word updates
// that copy and queues the output words it should produce. Each accepted output
// word is checked field by field against the oldest queued one.
//
// Stimulus runs in three parts:
//   - a directed burst at the reset settings (corners, bad ids, locked
//     neighbors, a query with nothing listed, clear), sent while the
//     receiver is held off so the block fills up
//   - twelve random phases, each with its own side / honor_locks setting,
//     among them side 0 (acts as 1), side 1, side 64 and sides above 64
//   - a drain with a short tail to catch stray output words
// Registers are only written once the block is idle. Clear, and lock or unlock
// of an in-grid id, make no output word, so after the last expected word we
// also wait out the clear sweep (input ready low) plus a short margin.

module tb_top;
    import gne_pkg::*;

    localparam int MAP_CELLS = DEF_MAX_SIDE * DEF_MAX_SIDE;

    // -------------------------------------------------------------------
    // Scoreboard: predictor state plus the queue of expected output words
    // -------------------------------------------------------------------
    class neighbor_scoreboard;
        bit                blocked_cells [MAP_CELLS];
        logic [SIDE_W-1:0] grid_side;
        logic              honor_locks;
        t_result           expected_neighbors [$];
        int                errors;

        function new();
            grid_side   = RST_GRID_SIDE;
            honor_locks = RST_HONOR_LOCKS;
            foreach (blocked_cells[i]) blocked_cells[i] = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_GRID_SIDE) grid_side = data;
            else honor_locks = data[0];
        endfunction

        function int effective_side();
            if (grid_side == 0) return 1;
            if (grid_side > DEF_MAX_SIDE) return DEF_MAX_SIDE;
            return int'(grid_side);
        endfunction

        function bit is_open(int nb);
            return !honor_locks || !blocked_cells[nb - 1];
        endfunction

        function void push_word(logic nvalid, int nid, logic [CTR_W-1:0] cx,
                                logic [CTR_W-1:0] cy, logic bad, logic last);
            t_result w;
            w.nvalid = nvalid;
            w.nid    = ID_W'(nid);
            w.cx     = cx;
            w.cy     = cy;
            w.bad    = bad;
            w.last   = last;
            expected_neighbors.insert(expected_neighbors.size(), w);
        endfunction

        // accepted input word: update map copy, queue the words it causes
        function void take_command(t_cmd cmd, logic [ID_W-1:0] id);
            int               side;
            int               cells;
            int               cid;
            int               col;
            int               row;
            int               n;
            int               nb_list [NB_N];
            logic [CTR_W-1:0] cx;
            logic [CTR_W-1:0] cy;

            side  = effective_side();
            cells = side * side;
            cid   = int'(id);
            n     = 0;

            if (cmd == CMD_CLEAR) begin
                foreach (blocked_cells[i]) blocked_cells[i] = 1'b0;
                return;
            end
            if (cid == 0 || cid > cells) begin
                push_word(1'b0, 0, '0, '0, 1'b1, 1'b1);
                return;
            end
            if (cmd == CMD_LOCK || cmd == CMD_UNLOCK) begin
                blocked_cells[cid - 1] = (cmd == CMD_LOCK);
                return;
            end

            col = (cid - 1) % side;
            row = (cid - 1) / side;
            cx  = CTR_W'(2 * col + 1);
            cy  = CTR_W'(2 * row + 1);

            // left, right, up, down
            if (col > 0 && is_open(cid - 1)) nb_list[n++] = cid - 1;
            if (col + 1 < side && is_open(cid + 1)) nb_list[n++] = cid + 1;
            if (row > 0 && is_open(cid - side)) nb_list[n++] = cid - side;
            if (row + 1 < side && is_open(cid + side)) nb_list[n++] = cid + side;

            if (n == 0) begin
                push_word(1'b0, 0, cx, cy, 1'b0, 1'b1);
                return;
            end
            for (int k = 0; k < n; k++)
                push_word(1'b1, nb_list[k], cx, cy, 1'b0, k == n - 1);
        endfunction

        task note_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_neighbor(t_result got);
            t_result w;
            string   diff;

            if (expected_neighbors.size() == 0) begin
                note_mismatch($sformatf("unexpected word id=%0d v=%0b bad=%0b last=%0b",
                                        got.nid, got.nvalid, got.bad, got.last));
                return;
            end
            w    = expected_neighbors.pop_front();
            diff = "";
            if (got.nvalid !== w.nvalid)
                diff = {diff, $sformatf(" neighbor_valid %0b/%0b", got.nvalid, w.nvalid)};
            if (got.nid !== w.nid)
                diff = {diff, $sformatf(" neighbor_id %0d/%0d", got.nid, w.nid)};
            if (got.cx !== w.cx)
                diff = {diff, $sformatf(" center_x_half %0d/%0d", got.cx, w.cx)};
            if (got.cy !== w.cy)
                diff = {diff, $sformatf(" center_y_half %0d/%0d", got.cy, w.cy)};
            if (got.bad !== w.bad)
                diff = {diff, $sformatf(" bad_cell %0b/%0b", got.bad, w.bad)};
            if (got.last !== w.last)
                diff = {diff, $sformatf(" last %0b/%0b", got.last, w.last)};
            if (diff != "") note_mismatch({"got/exp:", diff});
        endtask

        function int pending();
            return expected_neighbors.size();
        endfunction
    endclass

    // -------------------------------------------------------------------
    // DUT signals, inputs known from time zero
    // -------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [12:0] cell_id
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;   // [1:0] command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [12:0] neighbor_id,
                                                  // [19:13] center_x_half,
                                                  // [26:20] center_y_half
    logic [OUT_TUSER_W-1:0] m_axis_tuser;         // [0] neighbor_valid, [1] bad_cell
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    neighbor_scoreboard sb;
    t_result            got_word;

    // idle percentages of sender and receiver, changed only at phase edges
    int tx_idle_pct = 17;
    int rx_idle_pct = 66;
    int clears_left = 3;    // each clear sweeps the whole map, keep them rare
    int prev_id     = 1;

    // long receiver hold-off, run by its own process
    bit   rx_hold_req = 1'b0;
    logic rx_hold     = 1'b0;

    grid_neighbor_enumerator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // -------------------------------------------------------------------
    // Receiver: random backpressure, forced low during the hold-off
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial begin
        wait (rx_hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        // long enough for the two-word queue and the output register to fill
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // -------------------------------------------------------------------
    // Output monitor: values read here are the ones sampled at the edge
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word.nvalid = m_axis_tuser[0];
            got_word.nid    = m_axis_tdata[ID_W-1:0];
            got_word.cx     = m_axis_tdata[ID_W +: CTR_W];
            got_word.cy     = m_axis_tdata[ID_W + CTR_W +: CTR_W];
            got_word.bad    = m_axis_tuser[1];
            got_word.last   = m_axis_tlast;
            sb.check_neighbor(got_word);
        end
    end

    // -------------------------------------------------------------------
    // Drivers
    // -------------------------------------------------------------------
    // Offer one input word after a random gap; returns on acceptance with
    // tvalid still high, so back-to-back words need no extra step.
    task automatic send_word(input t_cmd cmd, input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ID_W){1'b0}}, id};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_command(cmd, id);
    endtask

    // Register write; leaves i_cfg_valid high, caller drops it after the last one.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Sender stops and waits for every expected word.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Full idle: drained, any clear sweep finished, lock/unlock words retired.
    task automatic settle_idle();
        wait_drained();
        repeat (20) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // One random phase at a given setting.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] side, input logic honor,
                             input int n_items, input bit mid_drain);
        int               eff;
        int               cells;
        int               r;
        int               id_i;
        t_cmd             cmd;
        logic [ID_W-1:0]  id;

        settle_idle();
        write_reg(CFG_GRID_SIDE, side);
        write_reg(CFG_HONOR_LOCKS, {{(CFG_DATA_W - 1){1'b0}}, honor});
        i_cfg_valid <= 1'b0;

        eff   = (side == 0) ? 1 : (side > DEF_MAX_SIDE) ? DEF_MAX_SIDE : int'(side);
        cells = eff * eff;
        if (prev_id > cells) prev_id = 1;

        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // full-width noise, mostly out of range on small grids
                id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
            end else if (r < 14) begin
                id = $urandom_range(0, 1) ? '0 : ID_W'(cells + $urandom_range(1, 2));
            end else if (r < 54) begin
                // stay near the last cell so locks and queries meet
                case ($urandom_range(0, 4))
                    0: id_i = prev_id - 1;
                    1: id_i = prev_id + 1;
                    2: id_i = prev_id - eff;
                    3: id_i = prev_id + eff;
                    default: id_i = prev_id;
                endcase
                id = (id_i < 0) ? '0 : ID_W'(id_i);
            end else begin
                id = ID_W'($urandom_range(1, cells));
            end
            if (id != 0 && int'(id) <= cells) prev_id = int'(id);

            r = $urandom_range(0, 99);
            if (r < 50) cmd = CMD_QUERY;
            else if (r < 74) cmd = CMD_LOCK;
            else if (r < 97) cmd = CMD_UNLOCK;
            else if (clears_left > 0) begin
                cmd = CMD_CLEAR;
                clears_left--;
            end else cmd = CMD_QUERY;

            send_word(cmd, id);
            if (mid_drain && k == n_items / 2) wait_drained();
        end
    endtask

    // -------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait out the map wipe after reset
        settle_idle();

        // receiver stalls while the sender keeps offering the burst
        rx_hold_req = 1'b1;

        // directed burst at reset settings: side 64, locks honored
        send_word(CMD_QUERY, 13'd1);        // top-left corner: right, down
        send_word(CMD_QUERY, 13'd64);       // top-right corner
        send_word(CMD_QUERY, 13'd4033);     // bottom-left corner
        send_word(CMD_QUERY, 13'd4096);     // last cell, top id bit set
        send_word(CMD_QUERY, 13'd2080);     // interior, all four
        send_word(CMD_QUERY, 13'd0);        // id zero
        send_word(CMD_QUERY, 13'd4097);     // just past the grid
        send_word(CMD_QUERY, 13'h1FFF);     // all id bits set
        send_word(CMD_LOCK, 13'd0);         // bad id on lock
        send_word(CMD_UNLOCK, 13'h1FFF);    // bad id on unlock
        send_word(CMD_LOCK, 13'd2);
        send_word(CMD_LOCK, 13'd65);
        send_word(CMD_QUERY, 13'd1);        // both neighbors blocked: none listed
        send_word(CMD_QUERY, 13'd66);       // left and up blocked
        send_word(CMD_LOCK, 13'd1);
        send_word(CMD_QUERY, 13'd1);        // queried cell blocked itself
        send_word(CMD_UNLOCK, 13'd2);
        send_word(CMD_QUERY, 13'd1);
        send_word(CMD_CLEAR, 13'h1555);     // id ignored on clear
        send_word(CMD_QUERY, 13'd66);
        send_word(CMD_LOCK, 13'd67);        // left behind for the resize phases
        send_word(CMD_LOCK, 13'd3);

        // random phases: idling regime changes every four phases
        for (int p = 0; p < 12; p++) begin
            case (p / 4)
                0: begin tx_idle_pct = 17; rx_idle_pct = 66; end
                1: begin tx_idle_pct = 66; rx_idle_pct = 17; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (p)
                0:  run_phase(7'd4, 1'b1, 25, 1'b0);
                1:  run_phase(7'd1, 1'b1, 20, 1'b0);
                2:  run_phase(7'd5, 1'b0, 25, 1'b0);
                3:  run_phase(7'd0, 1'b1, 20, 1'b0);     // side zero acts as one
                4:  run_phase(7'd64, 1'b1, 25, 1'b0);
                5:  run_phase(7'd3, 1'b1, 25, 1'b1);     // sender pauses mid-phase
                6:  run_phase(7'd2, 1'b0, 25, 1'b0);
                7:  run_phase(7'd127, 1'b1, 25, 1'b0);   // clamps to the max side
                8:  run_phase(7'd7, 1'b1, 25, 1'b0);
                9:  run_phase(7'd6, 1'b1, 25, 1'b0);
                10: run_phase(7'd8, 1'b0, 25, 1'b0);
                default: run_phase(7'd65, 1'b1, 25, 1'b0);
            endcase
        end

        // drain, then a tail to catch stray words
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hard limit, far above the slowest correct run
    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
hdl/gne_pkg.sv
hdl/gne_front.sv
hdl/gne_div.sv
hdl/gne_back.sv
hdl/grid_neighbor_enumerator_unit.sv
tb/sv/tb_top.sv
